/* hw/rtl/salsa12_stream_cipher_core_macros.svh */
// assertion macros for the salsa12 cipher rtl, used by the sequencer
`ifndef SALSA12_STREAM_CIPHER_CORE_MACROS_SVH
`define SALSA12_STREAM_CIPHER_CORE_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define S12_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("s12 check failed");

// next-cycle implication, sampled on aclk, off during reset
`define S12_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("s12 check failed");

`endif

/* hw/rtl/s12_pkg.sv */
// shared types and constants for the salsa12 stream cipher core
`timescale 1ns / 1ps
package s12_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 6;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONST_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONST_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_FIRST   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_SECOND  = 3'd5;

    localparam logic [31:0] IV_FIRST_RESET  = 32'h9BCEF411;
    localparam logic [31:0] IV_SECOND_RESET = 32'hE091B719;

    localparam logic [6:0] BLOCK_BYTES = 7'd64;

    // sixteen 32-bit words, element i is matrix word i
    typedef logic [15:0][31:0] matrix_t;

    // classified command as it sits in the queue
    typedef struct packed {
        logic        seek;
        logic [7:0]  data_byte;
        logic [31:0] blk;
        logic [5:0]  offset;
    } cmd_t;

    typedef struct packed {
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic [63:0] const_low;
        logic [63:0] const_high;
        logic [31:0] iv_first;
        logic [31:0] iv_second;
    } cfg_t;

endpackage

/* hw/rtl/salsa12_stream_cipher_core.sv */
// top level of the salsa12 byte stream cipher with its configuration registers
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid/tready       tdata: data_byte, position; tuser: operation
//  m_axis   out  m_axis_tvalid/tready       tdata: out_byte
//  cfg      in   cfg_wr_en (no back-press)  cfg_index, cfg_wdata
//
// a crypt byte with keystream left in the buffer is loaded into the output register once it is free
// a new block goes through a start step, the round steps, the feed-forward add
// and an emit step; a seek goes through the same without the emit and gives no output
// the input stage register and the command queue lie ahead of the sequencer
// reset is synchronous and leaves the stream as after a seek to byte zero
// a stalled output holds only the sequencer's byte emits; the queue keeps taking input until full
`timescale 1ns / 1ps
module salsa12_stream_cipher_core #(
    parameter int DOUBLE_ROUNDS = s12_pkg::DOUBLE_ROUNDS_DEF,
    parameter int QUEUE_DEPTH   = s12_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [s12_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // data_byte[7:0], position[45:8]
    input  logic                           s_axis_tuser,  // operation
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [s12_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // out_byte[7:0]
    input  logic                           cfg_wr_en,
    input  logic [s12_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [s12_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import s12_pkg::*;

    cfg_t cfg_reg;
    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic q_valid;
    logic q_pop;
    cmd_t q_data;

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.key_low    <= '0;
            cfg_reg.key_high   <= '0;
            cfg_reg.const_low  <= '0;
            cfg_reg.const_high <= '0;
            cfg_reg.iv_first   <= IV_FIRST_RESET;
            cfg_reg.iv_second  <= IV_SECOND_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_KEY_LOW:    cfg_reg.key_low    <= cfg_wdata;
                CFG_KEY_HIGH:   cfg_reg.key_high   <= cfg_wdata;
                CFG_CONST_LOW:  cfg_reg.const_low  <= cfg_wdata;
                CFG_CONST_HIGH: cfg_reg.const_high <= cfg_wdata;
                CFG_IV_FIRST:   cfg_reg.iv_first   <= cfg_wdata[31:0];
                CFG_IV_SECOND:  cfg_reg.iv_second  <= cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    s12_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    s12_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .pop_valid (q_valid),
        .pop_ready (q_pop),
        .pop_data  (q_data)
    );

    s12_back #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_data       (q_data),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

endmodule

/* hw/rtl/s12_front.sv */
// input stage: takes stream transfers and classifies them into commands
`timescale 1ns / 1ps
module s12_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [s12_pkg::S_TDATA_W-1:0] s_axis_tdata,  // data_byte[7:0], position[45:8]
    input  logic                          s_axis_tuser,  // operation
    output logic                          push_valid,
    input  logic                          push_ready,
    output s12_pkg::cmd_t                 push_data
);
    import s12_pkg::*;

    logic stage_valid_reg;
    cmd_t stage_reg;
    cmd_t stage_next;

    assign s_axis_tready = !stage_valid_reg || push_ready;
    assign push_valid    = stage_valid_reg;
    assign push_data     = stage_reg;

    // split the position into block number and offset inside the block
    always_comb begin
        stage_next.seek      = s_axis_tuser;
        stage_next.data_byte = s_axis_tdata[7:0];
        stage_next.blk       = s_axis_tdata[45:14];
        stage_next.offset    = s_axis_tdata[13:8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            stage_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            stage_reg <= stage_next;
        end
    end

endmodule

/* hw/rtl/s12_queue.sv */
// small command queue between the input stage and the cipher sequencer
`timescale 1ns / 1ps
module s12_queue #(
    parameter int DEPTH = s12_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  s12_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output s12_pkg::cmd_t pop_data
);
    import s12_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers wrap at the depth, count tracks occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/s12_rounds.sv */
// salsa round engine: one quarter-round line per cycle on all four quarters
`timescale 1ns / 1ps
module s12_rounds #(
    parameter int DOUBLE_ROUNDS = s12_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  s12_pkg::matrix_t init,
    output logic             done,
    output s12_pkg::matrix_t ks
);
    import s12_pkg::*;

    localparam int STEPS  = 8 * DOUBLE_ROUNDS;
    localparam int STEP_W = $clog2(STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

    localparam logic [1:0] EG_IDLE = 2'd0;
    localparam logic [1:0] EG_RUN  = 2'd1;
    localparam logic [1:0] EG_ADD  = 2'd2;

    // column quarters; rows are handled by transposing after each pass
    localparam logic [3:0][3:0] COL_A = {4'd15, 4'd10, 4'd5, 4'd0};
    localparam logic [3:0][3:0] COL_B = {4'd3, 4'd14, 4'd9, 4'd4};
    localparam logic [3:0][3:0] COL_C = {4'd7, 4'd2, 4'd13, 4'd8};
    localparam logic [3:0][3:0] COL_D = {4'd11, 4'd6, 4'd1, 4'd12};

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    matrix_t           x_reg;
    matrix_t           x_next;
    matrix_t           m_reg;
    matrix_t           m_next;
    matrix_t           y;
    matrix_t           yt;
    logic [31:0]       sum [4];
    logic [31:0]       rot [4];

    // one line of the quarter round, then roles shift a<-b<-c<-d<-a
    always_comb begin
        y = x_reg;
        for (int q = 0; q < 4; q++) begin
            sum[q] = x_reg[COL_A[q]] + x_reg[COL_D[q]];
            unique case (step_reg[1:0])
                2'd0: rot[q] = {sum[q][24:0], sum[q][31:25]};
                2'd1: rot[q] = {sum[q][22:0], sum[q][31:23]};
                2'd2: rot[q] = {sum[q][18:0], sum[q][31:19]};
                2'd3: rot[q] = {sum[q][13:0], sum[q][31:14]};
            endcase
            y[COL_A[q]] = x_reg[COL_B[q]] ^ rot[q];
            y[COL_B[q]] = x_reg[COL_C[q]];
            y[COL_C[q]] = x_reg[COL_D[q]];
            y[COL_D[q]] = x_reg[COL_A[q]];
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                yt[i * 4 + j] = y[j * 4 + i];
            end
        end
    end

    // final feed-forward add
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            ks[i] = x_reg[i] + m_reg[i];
        end
    end

    assign done = (phase_reg == EG_ADD);

    always_comb begin
        phase_next = phase_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        m_next     = m_reg;
        unique case (phase_reg)
            EG_IDLE: begin
                if (start) begin
                    x_next     = init;
                    m_next     = init;
                    step_next  = '0;
                    phase_next = EG_RUN;
                end
            end
            EG_RUN: begin
                x_next    = (step_reg[1:0] == 2'd3) ? yt : y;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    phase_next = EG_ADD;
                end
            end
            EG_ADD: begin
                phase_next = EG_IDLE;
            end
            default: begin
                phase_next = EG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= EG_IDLE;
            step_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        m_reg <= m_next;
    end

endmodule

/* hw/rtl/s12_back.sv */
// cipher sequencer: block counter, keystream buffer and output register
`timescale 1ns / 1ps
`include "salsa12_stream_cipher_core_macros.svh"
module s12_back #(
    parameter int DOUBLE_ROUNDS = s12_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  s12_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  s12_pkg::cmd_t                 q_data,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [s12_pkg::M_TDATA_W-1:0] m_axis_tdata  // out_byte
);
    import s12_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    logic [63:0]     counter_reg;
    logic [63:0]     counter_next;
    logic [6:0]      bytes_left_reg;
    logic [6:0]      bytes_left_next;
    cmd_t            cur_reg;
    cmd_t            cur_next;
    matrix_t         ks_reg;
    logic            m_valid_reg;
    logic [7:0]      m_data_reg;

    logic            out_free;
    logic            load_out;
    logic [7:0]      out_src;
    logic            eng_start;
    logic            eng_done;
    logic [63:0]     start_ctr;
    matrix_t         init;
    matrix_t         ks;
    logic [6:0]      used;
    logic [5:0]      idx;
    logic [3:0][7:0] ks_word;
    logic            crypt_block_done;
    logic            emit_full_block;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // next keystream byte, little-endian inside each word
    assign used    = BLOCK_BYTES - bytes_left_reg;
    assign idx     = used[5:0];
    assign ks_word = ks_reg[idx[5:2]];

    // state matrix for the block about to be made
    always_comb begin
        init[0]  = cfg.const_low[31:0];
        init[1]  = cfg.key_low[31:0];
        init[2]  = cfg.key_low[63:32];
        init[3]  = cfg.key_high[31:0];
        init[4]  = cfg.key_high[63:32];
        init[5]  = cfg.const_low[63:32];
        init[6]  = cfg.iv_first;
        init[7]  = cfg.iv_second;
        init[8]  = start_ctr[31:0];
        init[9]  = start_ctr[63:32];
        init[10] = cfg.const_high[31:0];
        init[11] = cfg.key_low[31:0];
        init[12] = cfg.key_low[63:32];
        init[13] = cfg.key_high[31:0];
        init[14] = cfg.key_high[63:32];
        init[15] = cfg.const_high[63:32];
    end

    s12_rounds #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_rounds (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (eng_start),
        .init   (init),
        .done   (eng_done),
        .ks     (ks)
    );

    // sequencer: buffered bytes go straight out, otherwise make a block first; a seek only makes its block
    always_comb begin
        state_next      = state_reg;
        counter_next    = counter_reg;
        bytes_left_next = bytes_left_reg;
        cur_next        = cur_reg;
        q_pop           = 1'b0;
        eng_start       = 1'b0;
        start_ctr       = counter_reg;
        load_out        = 1'b0;
        out_src         = cur_reg.data_byte;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (!q_data.seek && bytes_left_reg != 7'd0) begin
                        if (out_free) begin
                            q_pop           = 1'b1;
                            load_out        = 1'b1;
                            out_src         = q_data.data_byte;
                            bytes_left_next = bytes_left_reg - 7'd1;
                        end
                    end else begin
                        q_pop     = 1'b1;
                        eng_start = 1'b1;
                        cur_next  = q_data;
                        if (q_data.seek) begin
                            start_ctr = {32'd0, q_data.blk};
                        end
                        counter_next = start_ctr;
                        state_next   = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                if (eng_done) begin
                    counter_next = counter_reg + 64'd1;
                    if (cur_reg.seek) begin
                        bytes_left_next = BLOCK_BYTES - {1'b0, cur_reg.offset};
                        state_next      = ST_IDLE;
                    end else begin
                        bytes_left_next = BLOCK_BYTES;
                        state_next      = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_out        = 1'b1;
                    bytes_left_next = bytes_left_reg - 7'd1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            counter_reg    <= '0;
            bytes_left_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            counter_reg    <= counter_next;
            bytes_left_reg <= bytes_left_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (eng_done) begin
            ks_reg <= ks;
        end
        if (load_out) begin
            m_data_reg <= out_src ^ ks_word[idx[1:0]];
        end
    end

    // a crypt block finishing must be followed by emitting its first byte
    assign crypt_block_done = (state_reg == ST_WAIT) && eng_done && !cur_reg.seek;
    assign emit_full_block  = (state_reg == ST_EMIT) && (bytes_left_reg == BLOCK_BYTES);

    `S12_ASSERT_IMP(a_emit_has_bytes, load_out, bytes_left_reg != 7'd0)
    `S12_ASSERT_IMP(a_start_from_idle, eng_start, state_reg == ST_IDLE)
    `S12_ASSERT_IMP(a_done_while_waiting, eng_done, state_reg == ST_WAIT)
    `S12_ASSERT_IMP(a_bytes_in_range, 1'b1, bytes_left_reg <= BLOCK_BYTES)
    `S12_ASSERT_NXT(a_fresh_block_emits, crypt_block_done, emit_full_block)

endmodule

/* tb/testbench.sv */
// self-checking testbench for the salsa12 byte stream cipher core
`timescale 1ns / 1ps
module testbench;
    import s12_pkg::*;

    // operation codes carried on s_axis_tuser
    localparam logic OP_CRYPT = 1'b0;
    localparam logic OP_SEEK  = 1'b1;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // configuration patterns
    localparam int CFG_ALL_ONES  = 0;
    localparam int CFG_RANDOM    = 1;
    localparam int CFG_ALL_ZEROS = 2;

    // up to queue depth plus two seeks may still be in flight, each making one block,
    // and the wait for all of them is doubled
    localparam int SETTLE_CYCLES = 2 * (QUEUE_DEPTH_DEF + 2) * (8 * DOUBLE_ROUNDS_DEF + 3);
    localparam int STALL_LIMIT   = 4000;

    typedef struct packed {
        logic        op;
        logic [7:0]  data;
        logic [37:0] pos;
    } cipher_item_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = OP_CRYPT;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    cipher_item_t pending_items[$];
    logic [7:0]   expected_out_bytes[$];
    logic         in_taken = 1'b0;
    int           sender_idle_pct = 34;
    int           receiver_idle_pct = 66;
    int           err_count = 0;
    int           queued_total = 0;
    int           stall_cycles = 0;

    // shadow registers and keystream state of the predictor
    logic [63:0]  key_lo_q   = '0;
    logic [63:0]  key_hi_q   = '0;
    logic [63:0]  const_lo_q = '0;
    logic [63:0]  const_hi_q = '0;
    logic [31:0]  iv0_q      = IV_FIRST_RESET;
    logic [31:0]  iv1_q      = IV_SECOND_RESET;
    matrix_t      ks_words   = '0;
    logic [6:0]   ks_left    = '0;
    logic [63:0]  blk_ctr    = '0;

    salsa12_stream_cipher_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // data_byte[7:0], position[45:8]
        .s_axis_tuser  (s_axis_tuser),  // operation
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),  // out_byte[7:0]
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic matrix_t quarter_round(input matrix_t v, input int a, input int b,
                                              input int c, input int d);
        matrix_t x;
        x = v;
        x[b] ^= rotl32(x[a] + x[d], 7);
        x[c] ^= rotl32(x[b] + x[a], 9);
        x[d] ^= rotl32(x[c] + x[b], 13);
        x[a] ^= rotl32(x[d] + x[c], 18);
        return x;
    endfunction

    // 64 keystream bytes for one counter value under the current registers
    function automatic matrix_t salsa_block(input logic [63:0] ctr);
        matrix_t m;
        matrix_t x;
        m[0]  = const_lo_q[31:0];
        m[5]  = const_lo_q[63:32];
        m[10] = const_hi_q[31:0];
        m[15] = const_hi_q[63:32];
        m[1]  = key_lo_q[31:0];
        m[2]  = key_lo_q[63:32];
        m[3]  = key_hi_q[31:0];
        m[4]  = key_hi_q[63:32];
        m[11] = key_lo_q[31:0];
        m[12] = key_lo_q[63:32];
        m[13] = key_hi_q[31:0];
        m[14] = key_hi_q[63:32];
        m[6]  = iv0_q;
        m[7]  = iv1_q;
        m[8]  = ctr[31:0];
        m[9]  = ctr[63:32];
        x = m;
        for (int r = 0; r < DOUBLE_ROUNDS_DEF; r++) begin
            x = quarter_round(x, 0, 4, 8, 12);
            x = quarter_round(x, 5, 9, 13, 1);
            x = quarter_round(x, 10, 14, 2, 6);
            x = quarter_round(x, 15, 3, 7, 11);
            x = quarter_round(x, 0, 1, 2, 3);
            x = quarter_round(x, 5, 6, 7, 4);
            x = quarter_round(x, 10, 11, 8, 9);
            x = quarter_round(x, 15, 12, 13, 14);
        end
        for (int i = 0; i < 16; i++) begin
            x[i] = x[i] + m[i];
        end
        return x;
    endfunction

    // advance the keystream for one accepted command, queue the byte a crypt gives
    task automatic predict_cipher_byte(input logic op, input logic [7:0] data,
                                       input logic [37:0] pos);
        logic [6:0] idx;
        if (op == OP_SEEK) begin
            blk_ctr  = {32'd0, pos[37:6]};
            ks_words = salsa_block(blk_ctr);
            ks_left  = BLOCK_BYTES - {1'b0, pos[5:0]};
            blk_ctr  = blk_ctr + 64'd1;
        end else begin
            if (ks_left == 7'd0 || ks_left > BLOCK_BYTES) begin
                ks_words = salsa_block(blk_ctr);
                blk_ctr  = blk_ctr + 64'd1;
                ks_left  = BLOCK_BYTES;
            end
            idx = BLOCK_BYTES - ks_left;
            expected_out_bytes.push_back(data ^ ks_words[idx[5:2]][8 * idx[1:0] +: 8]);
            ks_left = ks_left - 7'd1;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // sample transfers and register writes at the rising edge
    always @(posedge aclk) begin
        in_taken <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_KEY_LOW:    key_lo_q   = cfg_wdata;
                    CFG_KEY_HIGH:   key_hi_q   = cfg_wdata;
                    CFG_CONST_LOW:  const_lo_q = cfg_wdata;
                    CFG_CONST_HIGH: const_hi_q = cfg_wdata;
                    CFG_IV_FIRST:   iv0_q      = cfg_wdata[31:0];
                    CFG_IV_SECOND:  iv1_q      = cfg_wdata[31:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_cipher_byte(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[45:8]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_out_bytes.size() == 0) begin
                    flag_mismatch($sformatf("unexpected out_byte %02h", m_axis_tdata));
                end else begin
                    logic [7:0] want;
                    want = expected_out_bytes.pop_front();
                    if (m_axis_tdata !== want)
                        flag_mismatch($sformatf("out_byte got %02h expected %02h",
                                                m_axis_tdata, want));
                end
            end
        end
    end

    // input driver and output back-pressure, changed at the falling edge
    always @(negedge aclk) begin
        cipher_item_t item;
        if (!s_axis_tvalid || in_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, item.pos, item.data};
                s_axis_tuser  <= item.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // watchdog on cycles without any transfer or register write
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[salsa12_stream_cipher_core] ERROR");
                $finish;
            end
        end
    end

    task automatic push_item(input logic op, input logic [7:0] data, input logic [37:0] pos);
        cipher_item_t item;
        item.op   = op;
        item.data = data;
        item.pos  = pos;
        pending_items.push_back(item);
        queued_total++;
    endtask

    function automatic logic [37:0] pick_position();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(3))
            0: return r[37:0];
            1: return 38'($urandom_range(255));
            2: return {r[31:0], 6'd63};
            default: return {32'hFFFF_FFFF, r[5:0]};
        endcase
    endfunction

    // mostly byte runs across block borders, some led by a seek, some seek pairs and single bytes
    task automatic queue_random_traffic(input int n_items);
        int start;
        int run_len;
        int pick;
        start = queued_total;
        while (queued_total - start < n_items) begin
            pick = $urandom_range(99);
            run_len = 0;
            if (pick < 20) begin
                push_item(OP_SEEK, 8'($urandom), pick_position());
                run_len = $urandom_range(1, 140);
            end else if (pick < 85) begin
                run_len = $urandom_range(1, 100);
            end else if (pick < 93) begin
                push_item(OP_SEEK, 8'($urandom), pick_position());
                push_item(OP_SEEK, 8'($urandom), pick_position());
            end else begin
                run_len = 1;
            end
            if (run_len > n_items - (queued_total - start))
                run_len = n_items - (queued_total - start);
            repeat (run_len) push_item(OP_CRYPT, 8'($urandom), pick_position());
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    function automatic logic [63:0] cfg_value(input int style);
        case (style)
            CFG_ALL_ONES:  return '1;
            CFG_ALL_ZEROS: return '0;
            default:       return {$urandom, $urandom};
        endcase
    endfunction

    task automatic load_config(input int style);
        write_reg(CFG_KEY_LOW, cfg_value(style));
        write_reg(CFG_KEY_HIGH, cfg_value(style));
        write_reg(CFG_CONST_LOW, cfg_value(style));
        write_reg(CFG_CONST_HIGH, cfg_value(style));
        write_reg(CFG_IV_FIRST, cfg_value(style));
        write_reg(CFG_IV_SECOND, cfg_value(style));
        write_reg(CFG_SPARE_A, {$urandom, $urandom});
        write_reg(CFG_SPARE_B, {$urandom, $urandom});
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait until every command is taken and every byte is out, then let the engine settle
    task automatic drain_block();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_out_bytes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: first block after reset, byte extremes, seeks to the edges
        push_item(OP_CRYPT, 8'h00, 38'd0);
        push_item(OP_CRYPT, 8'hFF, '1);
        push_item(OP_CRYPT, 8'hA5, 38'd0);
        push_item(OP_SEEK, 8'hFF, 38'd0);
        push_item(OP_CRYPT, 8'h3C, 38'd0);
        push_item(OP_SEEK, 8'h00, '1);
        push_item(OP_CRYPT, 8'h00, 38'd0);
        // counter carries into the high word here
        push_item(OP_CRYPT, 8'hFF, 38'd0);
        push_item(OP_CRYPT, 8'h81, 38'd0);
        push_item(OP_SEEK, 8'h5A, 38'd382);
        push_item(OP_CRYPT, 8'h01, 38'd0);
        push_item(OP_CRYPT, 8'h02, 38'd0);
        push_item(OP_CRYPT, 8'h04, 38'd0);
        push_item(OP_SEEK, 8'h00, {32'hFFFF_FFFF, 6'd0});
        push_item(OP_CRYPT, 8'h12, 38'd0);
        // back-to-back seeks
        push_item(OP_SEEK, 8'h00, 38'd100);
        push_item(OP_SEEK, 8'hFF, 38'd200);
        push_item(OP_CRYPT, 8'h55, 38'd0);
        push_item(OP_SEEK, 8'h00, 38'd63);
        push_item(OP_CRYPT, 8'hC3, 38'd0);
        push_item(OP_CRYPT, 8'h7E, 38'd0);
        drain_block();

        load_config(CFG_ALL_ONES);
        queue_random_traffic(120);
        drain_block();

        sender_idle_pct   = 66;
        receiver_idle_pct = 34;
        load_config(CFG_RANDOM);
        queue_random_traffic(120);
        drain_block();

        load_config(CFG_ALL_ZEROS);
        queue_random_traffic(120);
        drain_block();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        load_config(CFG_RANDOM);
        queue_random_traffic(120);
        drain_block();

        if (err_count == 0) begin
            $display("[salsa12_stream_cipher_core] OK");
        end else begin
            $display("[salsa12_stream_cipher_core] ERROR");
        end
        $finish;
    end

endmodule
